// ===== design/ring_buffer_fenced_allocator_unit_assert.svh =====
// Assertion macros for the ring allocator.
`ifndef RING_BUFFER_FENCED_ALLOCATOR_UNIT_ASSERT_SVH
`define RING_BUFFER_FENCED_ALLOCATOR_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rba check failed");

// Next-cycle implication.
`define RBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rba check failed");

`endif

// ===== design/rbfa_pkg.sv =====
package rbfa_pkg;

  localparam int REGION_SLOTS_DEF = 16;
  localparam int ADDR_BITS_DEF    = 24;
  localparam int COUNT_BITS_DEF   = $clog2(REGION_SLOTS_DEF + 1);

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTHING  = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_CAPACITY = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_DONE = 1'b1;

  // byte addresses on the APB port
  localparam logic [2:0] CFG_INITIAL_SIZE   = 3'd0;
  localparam logic [2:0] CFG_SIZE_INCREMENT = 3'd4;

  typedef struct packed {
    logic                     req_type;
    logic [ADDR_BITS_DEF-1:0] data_size;
    logic [12:0]              alignment;
    logic [31:0]              completed_seq;
  } rbfa_in_t;

  typedef struct packed {
    logic [2:0]                status;
    logic [ADDR_BITS_DEF-1:0]  out_offset;
    logic                      grew;
    logic [ADDR_BITS_DEF-1:0]  buffer_bytes;
    logic [COUNT_BITS_DEF-1:0] regions_live;
  } rbfa_out_t;

endpackage

// ===== design/ring_buffer_fenced_allocator_unit.sv =====
// Fenced ring suballocator. Raise start with an item while busy is low; busy is
// high from the accepting edge until the result cycle ends, and out_valid pulses
// for one cycle with the single result item, which the receiver must take then
// (it cannot stall). A done item passes through S_DONE, then the result cycle
// S_OUT. A put first walks the trim loop through S_TRD and S_TCHK for each
// region popped from the front (one registered region store read, then the
// completion test), ends the walk in S_TRD on an empty queue or in S_TCHK on a
// live head, then reads the head and newest regions and tests the fit in
// S_HREAD, S_BREAD and S_FIT. A put that places data then runs the subtractor
// over ADDR_BITS + 2 = 26 quotient bits of restoring division (one quotient bit
// per cycle) to round the offset up to the alignment, then multiplies in S_MUL,
// places the region in S_PLACE and gives the result in S_OUT. A put refused
// before placement skips the divide and goes from S_FIT to S_OUT. The next item
// can be taken in the cycle after the result. Configuration writes via the APB
// port are taken only while idle; writing initial_size empties the queue and
// loads the buffer size.
module ring_buffer_fenced_allocator_unit
  import rbfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  rbfa_in_t  in_item,
  output logic      out_valid,
  output rbfa_out_t out_item,
  input  logic      cfg_psel,
  input  logic      cfg_penable,
  input  logic      cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic      cfg_pready
);

`include "ring_buffer_fenced_allocator_unit_assert.svh"

  localparam int REGION_SLOTS = REGION_SLOTS_DEF;
  localparam int ADDR_BITS    = ADDR_BITS_DEF;
  localparam int SW = $clog2(REGION_SLOTS);
  localparam int CW = COUNT_BITS_DEF;
  localparam int NW = ADDR_BITS + 2;        // need/offset width incl. carry
  localparam int QW = $clog2(NW + 1);
  localparam logic [NW-1:0] CAP = NW'((64'd1 << ADDR_BITS) - 64'd1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_TRD   = 11'b00000000010, // issue head read
    S_TCHK  = 11'b00000000100, // test completion
    S_HREAD = 11'b00000001000, // read head start
    S_BREAD = 11'b00000010000, // read back region
    S_FIT   = 11'b00000100000,
    S_DIV   = 11'b00001000000,
    S_MUL   = 11'b00010000000,
    S_PLACE = 11'b00100000000,
    S_DONE  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // region store, one read port, registered read data
  logic [ADDR_BITS-1:0] mem_start [REGION_SLOTS];
  logic [NW-1:0]        mem_len   [REGION_SLOTS];
  logic [31:0]          mem_fence [REGION_SLOTS];
  logic [REGION_SLOTS-1:0] fenced_r;
  logic [SW-1:0]   rd_addr;
  logic [ADDR_BITS-1:0] rd_start_r;
  logic [NW-1:0]   rd_len_r;
  logic [31:0]     rd_fence_r;

  logic [SW-1:0] head_r, tail_r, back;
  logic [CW-1:0] count_r;
  logic [ADDR_BITS-1:0] cur_size_r, init_r, inc_r;
  logic pending_r;
  logic [31:0] fence_ctr_r;

  rbfa_in_t  req_r;
  rbfa_out_t res_r;
  logic [NW-1:0] need_r, at_r, off_r, head_start_r;
  logic [NW-1:0] div_rem_r, quo_r;
  logic [12:0]   align_r;
  logic [QW-1:0] bit_r;
  logic          grew_r;

  logic cfg_wr;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == CFG_SIZE_INCREMENT) ? 32'(inc_r) : 32'(init_r);

  function automatic logic [SW-1:0] nxt_slot(input logic [SW-1:0] i);
    return (32'(i) + 1 >= REGION_SLOTS) ? '0 : SW'(32'(i) + 1);
  endfunction

  assign back = (tail_r == '0) ? SW'(REGION_SLOTS - 1) : SW'(32'(tail_r) - 1);
  assign busy = (state_r != S_IDLE);

  always_comb begin
    rd_addr = head_r;
    if (state_r == S_HREAD) begin
      rd_addr = back;
    end
  end

  always_ff @(posedge clk) begin
    rd_start_r <= mem_start[rd_addr];
    rd_len_r   <= mem_len[rd_addr];
    rd_fence_r <= mem_fence[rd_addr];
    if (state_r == S_PLACE) begin
      mem_start[tail_r] <= head_start_r[ADDR_BITS-1:0];
      mem_len[tail_r]   <= need_r;
    end
    if (state_r == S_DONE && pending_r && count_r != '0) begin
      mem_fence[back] <= fence_ctr_r + 32'd1;
    end
  end

  // division subtractor, one restoring-division step per cycle
  logic [NW:0] sub_a, sub_b, diff;
  logic [31:0] seq_d;
  assign seq_d = req_r.completed_seq - rd_fence_r;
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    if (state_r == S_DIV) begin
      sub_a = {div_rem_r, at_r[bit_r]} ;
      sub_b = {(NW-12)'(0), align_r};
    end
    diff = sub_a - sub_b;
  end

  logic [NW-1:0] tot, end_v, new_size, at_nxt;
  logic fit, fit_stop;
  always_comb begin
    tot   = NW'(cur_size_r);
    end_v = head_start_r;
    fit   = 1'b0;
    at_nxt = off_r;
    if (count_r == '0) begin
      fit = need_r <= tot;
      at_nxt = '0;
    end else if (end_v < off_r) begin
      if (off_r < tot && need_r < tot - off_r) begin
        fit = 1'b1;
      end else if (need_r < end_v) begin
        fit = 1'b1;
        at_nxt = '0;
      end
    end else begin
      fit = end_v >= off_r + need_r;
    end
    if (tot < need_r + NW'(inc_r)) begin
      new_size = need_r + NW'(inc_r);
    end else if (inc_r != '0) begin
      new_size = tot + NW'(inc_r);
    end else begin
      new_size = tot << 1;
    end
    // put refused before placement: straight to the result
    fit_stop = (req_r.data_size == '0) || (cur_size_r == '0) ||
               (fit ? (32'(count_r) >= REGION_SLOTS) : (new_size > CAP));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = (in_item.req_type == REQ_DONE) ? S_DONE : S_TRD;
      S_TRD:   state_nxt = (count_r == '0) ? S_HREAD : S_TCHK;
      S_TCHK:  state_nxt = (fenced_r[head_r] && !seq_d[31]) ? S_TRD : S_HREAD;
      S_HREAD: state_nxt = S_BREAD;
      S_BREAD: state_nxt = S_FIT;
      S_FIT:   state_nxt = fit_stop ? S_OUT : S_DIV;
      S_DIV:   state_nxt = (bit_r == '0) ? S_MUL : S_DIV;
      S_MUL:   state_nxt = S_PLACE;
      S_PLACE: state_nxt = S_OUT;
      S_DONE:  state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fenced_r <= '0;
      head_r <= '0; tail_r <= '0; count_r <= '0;
      cur_size_r <= '0; init_r <= '0; inc_r <= '0;
      pending_r <= 1'b0; fence_ctr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && state_r == S_IDLE) begin
        if (cfg_paddr == CFG_INITIAL_SIZE) begin
          init_r <= cfg_pwdata[ADDR_BITS-1:0];
          cur_size_r <= cfg_pwdata[ADDR_BITS-1:0];
          head_r <= '0; tail_r <= '0; count_r <= '0;
          pending_r <= 1'b0;
        end else if (cfg_paddr == CFG_SIZE_INCREMENT) begin
          inc_r <= cfg_pwdata[ADDR_BITS-1:0];
        end
      end
      case (state_r)
        S_IDLE: if (start) begin
          req_r <= in_item;
          align_r <= (in_item.alignment == '0) ? 13'd1 : in_item.alignment;
          need_r <= NW'(in_item.data_size)
                  + NW'((in_item.alignment == '0) ? 13'd1 : in_item.alignment);
          grew_r <= 1'b0;
          res_r.status <= ST_NOTHING;
          res_r.out_offset <= '0;
        end
        S_TRD: if (count_r == '0) begin end
        S_TCHK: if (fenced_r[head_r] && !seq_d[31]) begin
          fenced_r[head_r] <= 1'b0;
          head_r <= nxt_slot(head_r);
          count_r <= count_r - CW'(1);
        end
        S_HREAD: begin
          pending_r <= 1'b0;
          head_start_r <= NW'(rd_start_r);
        end
        S_BREAD: off_r <= NW'(rd_start_r) + rd_len_r;
        S_FIT: begin
          bit_r <= QW'(NW - 1);
          div_rem_r <= '0;
          if (req_r.data_size == '0) begin
            res_r.status <= ST_NOTHING;
          end else if (cur_size_r == '0) begin
            res_r.status <= ST_INVALID;
          end else if (fit) begin
            if (32'(count_r) >= REGION_SLOTS) begin
              res_r.status <= ST_FULL;
            end else begin
              at_r <= at_nxt + NW'(align_r) - NW'(1);
              head_start_r <= at_nxt;
            end
          end else begin
            head_r <= '0; tail_r <= '0; count_r <= '0;
            if (new_size > CAP) begin
              res_r.status <= ST_CAPACITY;
            end else begin
              cur_size_r <= new_size[ADDR_BITS-1:0];
              grew_r <= 1'b1;
              at_r <= NW'(align_r) - NW'(1);
              head_start_r <= '0;
            end
          end
        end
        S_DIV: begin
          if (!diff[NW]) begin
            div_rem_r <= diff[NW-1:0];
            quo_r[bit_r] <= 1'b1;
          end else begin
            div_rem_r <= sub_a[NW-1:0];
            quo_r[bit_r] <= 1'b0;
          end
          if (bit_r != '0) bit_r <= bit_r - QW'(1);
        end
        S_MUL: off_r <= NW'(quo_r * NW'(align_r));
        S_PLACE: begin
          fenced_r[tail_r] <= 1'b0;
          tail_r <= nxt_slot(tail_r);
          count_r <= count_r + CW'(1);
          pending_r <= 1'b1;
          res_r.status <= ST_OK;
          res_r.out_offset <= off_r[ADDR_BITS-1:0];
        end
        S_DONE: begin
          if (pending_r && count_r != '0) begin
            fence_ctr_r <= fence_ctr_r + 32'd1;
            fenced_r[back] <= 1'b1;
            res_r.status <= ST_OK;
          end
          pending_r <= 1'b0;
        end
        default: begin end
      endcase
    end
  end

  always_comb begin
    out_valid = (state_r == S_OUT);
    out_item.status       = res_r.status;
    out_item.out_offset   = (res_r.status == ST_OK) ? res_r.out_offset : '0;
    out_item.grew         = grew_r && (res_r.status == ST_OK) && !req_r.req_type;
    out_item.buffer_bytes = cur_size_r;
    out_item.regions_live = count_r;
  end

  `RBA_ASSERT_IMP(a_count_range, 1'b1, 32'(count_r) <= REGION_SLOTS)
  `RBA_ASSERT_NXT(a_out_once, out_valid, !out_valid)
  `RBA_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `RBA_ASSERT_IMP(a_grew_ok, out_valid && out_item.grew, out_item.status == ST_OK)

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import rbfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = REGION_SLOTS_DEF;
  localparam longint CAP_LIMIT = (64'd1 << ADDR_BITS_DEF) - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 120;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  rbfa_in_t in_item;
  logic out_valid;
  rbfa_out_t out_item;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  ring_buffer_fenced_allocator_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite), .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  // Mirror of the allocator state
  logic [23:0] rg_start [SLOTS];
  logic [23:0] rg_len [SLOTS];
  logic        rg_fenced [SLOTS];
  logic [31:0] rg_fence_no [SLOTS];
  int unsigned q_head, q_tail, q_count;
  logic [23:0] cur_size;
  logic        put_pending;
  logic [31:0] fence_ctr;
  logic [23:0] init_size;
  logic [23:0] size_inc;

  rbfa_in_t  pending_items[$];
  rbfa_out_t expected_results[$];
  int errors = 0;
  int items_sent = 0;
  int sender_gap_pct = 19;
  int unsigned cycles = 0;
  int unsigned gen_fences = 0;

  function automatic int unsigned next_slot(int unsigned i);
    return (i + 1 >= SLOTS) ? 0 : i + 1;
  endfunction

  function automatic void stash_item(rbfa_in_t it);
    pending_items = {pending_items, it};
  endfunction

  // Free-space search: returns 1 and the start offset when need bytes fit
  function automatic bit find_room(longint need, output longint at);
    longint total, off, fin;
    int unsigned back;
    total = cur_size;
    if (q_count == 0) begin
      at = 0;
      return need <= total;
    end
    back = (q_tail == 0) ? SLOTS - 1 : q_tail - 1;
    off = longint'(rg_start[back]) + longint'(rg_len[back]);
    fin = rg_start[q_head];
    at = off;
    if (fin < off) begin
      if (off < total && need < total - off) return 1;
      if (need < fin) begin
        at = 0;
        return 1;
      end
      return 0;
    end
    return fin >= off + need;
  endfunction

  function automatic rbfa_out_t allocate_step(rbfa_in_t it);
    rbfa_out_t r;
    logic [31:0] diff;
    longint sz, algn, need, at, cur, inc, ns, offs;
    bit ok;
    r = '0;
    r.status = ST_NOTHING;
    offs = 0;
    if (it.req_type == REQ_PUT) begin
      put_pending = 0;
      // retire completed regions from the front
      while (q_count > 0) begin
        diff = it.completed_seq - rg_fence_no[q_head];
        if (!rg_fenced[q_head] || diff[31]) break;
        rg_fenced[q_head] = 0;
        q_head = next_slot(q_head);
        q_count--;
      end
      sz = it.data_size;
      algn = (it.alignment == 0) ? 1 : it.alignment;
      if (sz == 0) begin
        r.status = ST_NOTHING;
      end else if (cur_size == 0) begin
        r.status = ST_INVALID;
      end else begin
        need = sz + algn;
        ok = 1;
        if (find_room(need, at)) begin
          if (q_count >= SLOTS) begin
            r.status = ST_FULL;
            ok = 0;
          end
        end else begin
          cur = cur_size;
          inc = size_inc;
          at = 0;
          q_head = 0;
          q_tail = 0;
          q_count = 0;
          if (cur < need + inc) ns = need + inc;
          else if (inc != 0) ns = cur + inc;
          else ns = cur * 2;
          if (ns > CAP_LIMIT) begin
            r.status = ST_CAPACITY;
            ok = 0;
          end else begin
            cur_size = ns[23:0];
            r.grew = 1;
          end
        end
        if (ok) begin
          offs = (at + algn - 1) / algn * algn;
          rg_start[q_tail] = at[23:0];
          rg_len[q_tail] = need[23:0];
          rg_fenced[q_tail] = 0;
          rg_fence_no[q_tail] = '0;
          q_tail = next_slot(q_tail);
          q_count++;
          put_pending = 1;
          r.status = ST_OK;
        end
      end
    end else begin
      if (put_pending && q_count > 0) begin
        fence_ctr = fence_ctr + 1;
        rg_fence_no[(q_tail == 0) ? SLOTS - 1 : q_tail - 1] = fence_ctr;
        rg_fenced[(q_tail == 0) ? SLOTS - 1 : q_tail - 1] = 1;
        r.status = ST_OK;
      end
      put_pending = 0;
    end
    r.out_offset = (r.status == ST_OK) ? offs[23:0] : '0;
    r.buffer_bytes = cur_size;
    r.regions_live = q_count[4:0];
    return r;
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Driver: one item held on in_item until the edge that takes it
  always @(posedge clk) begin
    rbfa_in_t nxt;
    bit take_next;
    if (rst_n) begin
      take_next = !start;
      if (start && !busy) begin
        expected_results = {expected_results, allocate_step(in_item)};
        items_sent++;
        if (items_sent == 550) sender_gap_pct = 51;
        if (items_sent == 1100) sender_gap_pct = 0;
        take_next = 1;
      end
      if (take_next) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
          nxt = pending_items.pop_front();
          in_item <= nxt;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be held off, so every strobe is checked at once
  always @(posedge clk) begin
    rbfa_out_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $realtime, out_item);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_item.status !== exp_r.status || out_item.out_offset !== exp_r.out_offset ||
            out_item.grew !== exp_r.grew || out_item.buffer_bytes !== exp_r.buffer_bytes ||
            out_item.regions_live !== exp_r.regions_live) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, out_item);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= idx;
    cfg_pwdata <= {8'h00, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == CFG_INITIAL_SIZE) begin
      init_size = val;
      cur_size = val;
      q_head = 0;
      q_tail = 0;
      q_count = 0;
      put_pending = 0;
    end else begin
      size_inc = val;
    end
  endtask

  task automatic wait_idle();
    wait (pending_items.size() == 0 && !start && expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_put(logic [23:0] sz, logic [12:0] al, logic [31:0] seq);
    rbfa_in_t it;
    it.req_type = REQ_PUT;
    it.data_size = sz;
    it.alignment = al;
    it.completed_seq = seq;
    stash_item(it);
  endtask

  // Done items carry random bits in the unused fields
  task automatic add_done(logic [31:0] seq);
    rbfa_in_t it;
    it.req_type = REQ_DONE;
    it.data_size = 24'($urandom);
    it.alignment = 13'($urandom);
    it.completed_seq = seq;
    stash_item(it);
    gen_fences++;
  endtask

  function automatic logic [12:0] pick_align();
    int p;
    p = $urandom_range(99);
    if (p < 10) return 13'($urandom_range(0, 8191));
    if (p < 15) return 13'd4096;
    return 13'd1 << $urandom_range(0, 6);
  endfunction

  function automatic logic [31:0] pick_seq();
    int p;
    p = $urandom_range(99);
    if (p < 8) return $urandom;
    if (p < 12) return gen_fences + 32'h8000_0000;
    return gen_fences - $urandom_range(0, 6);
  endfunction

  function automatic logic [23:0] pick_size();
    int p;
    p = $urandom_range(99);
    if (p < 2) return '0;
    if (p < 5) return 24'($urandom);
    if (p < 12) return 24'($urandom_range(1, 4000));
    return 24'($urandom_range(1, 300));
  endfunction

  // Mostly put/done pairs; bursts of unfenced puts fill the queue
  task automatic add_random(int n);
    int k;
    int p;
    k = 0;
    while (k < n) begin
      p = $urandom_range(99);
      if (p < 70) begin
        add_put(pick_size(), pick_align(), pick_seq());
        add_done(pick_seq());
        k += 2;
      end else if (p < 75) begin
        repeat (18) add_put(24'($urandom_range(1, 20)), pick_align(), pick_seq());
        k += 18;
      end else if (p < 90) begin
        add_put(pick_size(), pick_align(), pick_seq());
        k++;
      end else begin
        add_done(pick_seq());
        k++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = CFG_INITIAL_SIZE;
    cfg_pwdata = '0;
    for (int i = 0; i < SLOTS; i++) begin
      rg_start[i] = '0;
      rg_len[i] = '0;
      rg_fenced[i] = 0;
      rg_fence_no[i] = '0;
    end
    q_head = 0;
    q_tail = 0;
    q_count = 0;
    cur_size = '0;
    put_pending = 0;
    fence_ctr = '0;
    init_size = '0;
    size_inc = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // buffer invalid out of reset
    add_put(24'd16, 13'd1, 32'd0);
    add_done(32'd0);
    add_put(24'd0, 13'd4, 32'd0);
    wait_idle();

    cfg_write(CFG_INITIAL_SIZE, 24'd1024);
    cfg_write(CFG_SIZE_INCREMENT, 24'd0);
    // directed: zero size, done with no put, zero and odd alignment,
    // largest size (capacity error), fence then retire, queue full
    add_put(24'd0, 13'd1, 32'd0);
    add_done(32'd0);
    add_put(24'd10, 13'd0, 32'd0);
    add_done(32'd0);
    add_put(24'd100, 13'd4096, 32'd1);
    add_done(32'd1);
    add_put(24'd33, 13'd8191, 32'd2);
    add_put(24'hFFFFFF, 13'd1, 32'hFFFF_FFFF);
    add_put(24'd700, 13'd64, 32'd0);
    add_put(24'd1500, 13'd2, 32'd0);
    repeat (17) add_put(24'd4, 13'd1, 32'd0);
    wait_idle();
    add_random(400);
    wait_idle();

    cfg_write(CFG_SIZE_INCREMENT, 24'd64);
    cfg_write(CFG_INITIAL_SIZE, 24'd256);
    add_random(400);
    wait_idle();

    cfg_write(CFG_INITIAL_SIZE, 24'hFFFFFF);
    cfg_write(CFG_SIZE_INCREMENT, 24'hFFFFFF);
    add_random(200);
    wait_idle();

    cfg_write(CFG_INITIAL_SIZE, 24'd1);
    cfg_write(CFG_SIZE_INCREMENT, 24'd1);
    add_random(300);
    wait_idle();

    cfg_write(CFG_INITIAL_SIZE, 24'd4096);
    cfg_write(CFG_SIZE_INCREMENT, 24'd0);
    add_random(330);
    wait_idle();

    if (errors == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
